>>> design/ata_pkg.sv
// types, constants and saturating fixed-point helpers for the affine transform accumulator
package ata_pkg;

  // element format: signed, FRAC_BITS fraction bits
  localparam int ELEM_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int PROD_WIDTH = 2 * ELEM_WIDTH;

  typedef logic signed [ELEM_WIDTH-1:0] elem_t;
  typedef logic signed [PROD_WIDTH-1:0] prod_t;

  localparam elem_t ELEM_MAX = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
  localparam elem_t ELEM_MIN = {1'b1, {(ELEM_WIDTH-1){1'b0}}};
  // unit value saturates if the fraction leaves no room for the integer one
  localparam elem_t UNIT = (FRAC_BITS >= ELEM_WIDTH - 1) ? ELEM_MAX
                                                         : (elem_t'(1) << FRAC_BITS);
  // added to a negative product before the shift so it truncates toward zero
  localparam prod_t ROUND_BIAS = PROD_WIDTH'((64'd1 << FRAC_BITS) - 64'd1);

  typedef enum logic [1:0] {
    OP_IDENTITY  = 2'd0,
    OP_TRANSLATE = 2'd1,
    OP_SCALE     = 2'd2,
    OP_ROTATE    = 2'd3
  } op_t;

  // quarter-turn codes, low two bits of transform_code
  typedef enum logic [1:0] {
    TURN_0   = 2'd0,
    TURN_90  = 2'd1,
    TURN_180 = 2'd2,
    TURN_270 = 2'd3
  } turn_t;

  typedef enum logic [1:0] {
    WT_ZERO = 2'd0,
    WT_POS  = 2'd1,
    WT_NEG  = 2'd2
  } weight_t;

  typedef struct packed {
    weight_t t00;
    weight_t t01;
    weight_t t10;
    weight_t t11;
  } rot_wt_t;

  typedef struct packed {
    op_t        operation;
    elem_t      arg_x;
    elem_t      arg_y;
    logic [2:0] transform_code;
  } src_item_t;

  typedef struct packed {
    elem_t elem_a;
    elem_t elem_b;
    elem_t elem_tx;
    elem_t elem_c;
    elem_t elem_d;
    elem_t elem_ty;
  } dst_item_t;

  localparam dst_item_t IDENTITY_MATRIX = '{
    elem_a: UNIT, elem_b: '0, elem_tx: '0,
    elem_c: '0, elem_d: UNIT, elem_ty: '0
  };

  // saturating add
  function automatic elem_t sat_add(elem_t a, elem_t b);
    logic signed [ELEM_WIDTH:0] s;
    s = $signed({a[ELEM_WIDTH-1], a}) + $signed({b[ELEM_WIDTH-1], b});
    if (s[ELEM_WIDTH] != s[ELEM_WIDTH-1]) begin
      return s[ELEM_WIDTH] ? ELEM_MIN : ELEM_MAX;
    end
    return $signed(s[ELEM_WIDTH-1:0]);
  endfunction

  // saturating negate
  function automatic elem_t sat_neg(elem_t a);
    if (a == ELEM_MIN) begin
      return ELEM_MAX;
    end
    return -a;
  endfunction

  // fixed-point product, truncated toward zero, saturated
  function automatic elem_t fx_mul(elem_t a, elem_t b);
    prod_t ax;
    prod_t bx;
    prod_t p;
    prod_t q;
    prod_t hi_lim;
    prod_t lo_lim;
    ax     = PROD_WIDTH'(a);
    bx     = PROD_WIDTH'(b);
    hi_lim = PROD_WIDTH'(ELEM_MAX);
    lo_lim = PROD_WIDTH'(ELEM_MIN);
    p      = ax * bx;
    q      = (p[PROD_WIDTH-1] ? (p + ROUND_BIAS) : p) >>> FRAC_BITS;
    if (q > hi_lim) begin
      return ELEM_MAX;
    end
    if (q < lo_lim) begin
      return ELEM_MIN;
    end
    return $signed(q[ELEM_WIDTH-1:0]);
  endfunction

  function automatic elem_t signed_term(elem_t v, weight_t w);
    case (w)
      WT_POS:  return v;
      WT_NEG:  return sat_neg(v);
      default: return '0;
    endcase
  endfunction

  function automatic weight_t flip_wt(weight_t w, logic flip);
    if (!flip) begin
      return w;
    end
    case (w)
      WT_POS:  return WT_NEG;
      WT_NEG:  return WT_POS;
      default: return WT_ZERO;
    endcase
  endfunction

  // diag(flip,1,1) times the quarter-turn matrix for a transform code
  function automatic rot_wt_t rot_weights(logic [2:0] code);
    rot_wt_t r;
    case (turn_t'(code[1:0]))
      TURN_90:  r = '{t00: WT_ZERO, t01: WT_NEG,  t10: WT_POS,  t11: WT_ZERO};
      TURN_180: r = '{t00: WT_NEG,  t01: WT_ZERO, t10: WT_ZERO, t11: WT_NEG};
      TURN_270: r = '{t00: WT_ZERO, t01: WT_POS,  t10: WT_NEG,  t11: WT_ZERO};
      default:  r = '{t00: WT_POS,  t01: WT_ZERO, t10: WT_ZERO, t11: WT_POS};
    endcase
    r.t00 = flip_wt(r.t00, code[2]);
    r.t01 = flip_wt(r.t01, code[2]);
    return r;
  endfunction

endpackage

>>> design/affine_transform_accumulator.sv
// affine transform accumulator: input register, matrix update, matrix result register
//
//  channel | signals                       | payload
//  --------+-------------------------------+------------------------------------------
//  src     | src_valid, src_ready          | src_item: operation, arg_x, arg_y, code
//  dst     | dst_valid, dst_ready          | dst_item: elem_a, b, tx, c, d, ty
//
// one item per cycle unless dst stalls; result valid once the item updates the matrix
// the matrix register is also the result register, updated by four multipliers
// and saturating adders combinationally from the input register
// reset loads the identity matrix and empties both stages
// a stalled result holds the matrix; one more item waits in the input register
module affine_transform_accumulator
  import ata_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      src_valid,
  output logic      src_ready,
  input  src_item_t src_item,
  output logic      dst_valid,
  input  logic      dst_ready,
  output dst_item_t dst_item
);

  logic      s1_valid;
  src_item_t s1_item;
  logic      advance;
  dst_item_t mat;
  dst_item_t mat_next;

  // handshake: item moves into the matrix when the result slot is free or being read
  assign advance   = s1_valid && (!dst_valid || dst_ready);
  assign src_ready = !s1_valid || advance;
  assign dst_item  = mat;

  // input register
  always_ff @(posedge clk) begin
    if (src_valid && src_ready) begin
      s1_item <= src_item;
    end
  end

  // control and matrix state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      dst_valid <= 1'b0;
      mat       <= IDENTITY_MATRIX;
    end else begin
      if (src_ready) begin
        s1_valid <= src_valid;
      end
      if (advance) begin
        dst_valid <= 1'b1;
        mat       <= mat_next;
      end else if (dst_ready) begin
        dst_valid <= 1'b0;
      end
    end
  end

  // products of the linear part with the arguments
  elem_t   p_ax, p_by, p_cx, p_dy;
  elem_t   sum_x, sum_y;
  rot_wt_t rw;

  assign p_ax  = fx_mul(mat.elem_a, s1_item.arg_x);
  assign p_by  = fx_mul(mat.elem_b, s1_item.arg_y);
  assign p_cx  = fx_mul(mat.elem_c, s1_item.arg_x);
  assign p_dy  = fx_mul(mat.elem_d, s1_item.arg_y);
  assign sum_x = sat_add(p_ax, p_by);
  assign sum_y = sat_add(p_cx, p_dy);
  assign rw    = rot_weights(s1_item.transform_code);

  // next matrix for the operation in the input register
  always_comb begin
    mat_next = mat;
    case (s1_item.operation)
      OP_IDENTITY: begin
        mat_next = IDENTITY_MATRIX;
      end
      OP_TRANSLATE: begin
        mat_next.elem_tx = sat_add(mat.elem_tx, sum_x);
        mat_next.elem_ty = sat_add(mat.elem_ty, sum_y);
      end
      OP_SCALE: begin
        mat_next.elem_a = p_ax;
        mat_next.elem_b = p_by;
        mat_next.elem_c = p_cx;
        mat_next.elem_d = p_dy;
      end
      OP_ROTATE: begin
        mat_next.elem_a = sat_add(signed_term(mat.elem_a, rw.t00),
                                  signed_term(mat.elem_b, rw.t10));
        mat_next.elem_b = sat_add(signed_term(mat.elem_a, rw.t01),
                                  signed_term(mat.elem_b, rw.t11));
        mat_next.elem_c = sat_add(signed_term(mat.elem_c, rw.t00),
                                  signed_term(mat.elem_d, rw.t10));
        mat_next.elem_d = sat_add(signed_term(mat.elem_c, rw.t01),
                                  signed_term(mat.elem_d, rw.t11));
      end
      default: begin
        mat_next = mat;
      end
    endcase
  end

  // reset leaves the identity matrix
  a_reset_identity: assert property (@(posedge clk)
    rst |=> mat == IDENTITY_MATRIX)
    else $error("matrix not identity after reset");

  // input stalls only when both stages are full and the result is held
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !src_ready |-> (s1_valid && dst_valid && !dst_ready))
    else $error("input stalled without cause");

  // translate never touches the linear part
  a_translate_linear: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_item.operation == OP_TRANSLATE) |=>
      (mat.elem_a == $past(mat.elem_a) && mat.elem_b == $past(mat.elem_b) &&
       mat.elem_c == $past(mat.elem_c) && mat.elem_d == $past(mat.elem_d)))
    else $error("translate changed linear part");

  // rotate never touches the translation
  a_rotate_translation: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_item.operation == OP_ROTATE) |=>
      (mat.elem_tx == $past(mat.elem_tx) && mat.elem_ty == $past(mat.elem_ty)))
    else $error("rotate changed translation");

  // matrix moves only when an item is applied
  a_matrix_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> mat == $past(mat))
    else $error("matrix changed without an item");

endmodule
